// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset disables the check
`define MPFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpfb assertion failed");

// next-cycle implication, reset disables the check
`define MPFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpfb assertion failed");

`endif

// File: sv/mpfb_pkg.sv
`default_nettype none

package mpfb_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int PAGE_ROWS      = 8;
    localparam int ROW_W          = $clog2(PAGE_ROWS);
    localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int FIELD_W        = 12;
    // corners of an outline reach twice the field range
    localparam int COORD_W        = FIELD_W + 2;
    localparam int ERR_W          = COORD_W + 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic [ADDR_W-1:0]         addr_t;

    typedef enum logic [2:0] {
        REQ_CLEAR     = 3'd0,
        REQ_SET_PIXEL = 3'd1,
        REQ_CLR_PIXEL = 3'd2,
        REQ_LINE      = 3'd3,
        REQ_RECT      = 3'd4,
        REQ_FILL      = 3'd5,
        REQ_READ      = 3'd6
    } req_e;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SEG_LOAD,
        ST_LINE_RD,
        ST_LINE_WR,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_READ_WAIT,
        ST_RESP
    } state_e;

    typedef struct packed {
        logic [2:0]                req_type;
        logic signed [FIELD_W-1:0] x_start;
        logic signed [FIELD_W-1:0] y_start;
        logic signed [FIELD_W-1:0] x_end;
        logic signed [FIELD_W-1:0] y_end;
        logic signed [FIELD_W-1:0] rect_width;
        logic signed [FIELD_W-1:0] rect_height;
    } req_item_t;

    typedef struct packed {
        logic       done_res;
        logic [7:0] read_byte;
    } res_item_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
    } line_seg_t;

    typedef struct packed {
        logic      load;
        logic      step;
        line_seg_t seg;
    } walk_ctl_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } walk_pos_t;

    function automatic logic on_display(coord_t x, coord_t y);
        return (x >= 0) && (x < coord_t'(DISPLAY_WIDTH))
            && (y >= 0) && (y < coord_t'(DISPLAY_HEIGHT));
    endfunction

    function automatic addr_t page_addr(coord_t x, coord_t page);
        addr_t xa;
        addr_t pa;
        xa = ADDR_W'(unsigned'(x));
        pa = ADDR_W'(unsigned'(page));
        return xa + pa * ADDR_W'(DISPLAY_WIDTH);
    endfunction

    function automatic addr_t pix_addr(coord_t x, coord_t y);
        return page_addr(x, y >>> ROW_W);
    endfunction

endpackage

`default_nettype wire

// File: sv/mpfb_ram.sv
`default_nettype none

module mpfb_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/mpfb_walk.sv
`default_nettype none

module mpfb_walk
    import mpfb_pkg::*;
(
    input  logic      clk,
    input  walk_ctl_t ctl,
    output walk_pos_t pos
);

    coord_t ax_reg, ay_reg, bx_reg, by_reg;
    coord_t ax_next, ay_next;
    err_t   dx_reg, dy_reg, err_reg;
    err_t   err_next;
    logic   sx_neg_reg, sy_neg_reg;

    err_t   ddx, ddy, ldx, ldy;
    err_t   e2;
    logic   move_x, move_y;

    always_comb
    begin
        ddx = err_t'(ctl.seg.bx) - err_t'(ctl.seg.ax);
        ddy = err_t'(ctl.seg.by) - err_t'(ctl.seg.ay);
        ldx = (ddx < 0) ? -ddx : ddx;
        ldy = (ddy < 0) ? -ddy : ddy;

        e2     = err_reg <<< 1;
        move_x = e2 > -dy_reg;
        move_y = e2 < dx_reg;

        err_next = err_reg;
        ax_next  = ax_reg;
        ay_next  = ay_reg;
        if (move_x)
        begin
            ax_next = ax_reg + (sx_neg_reg ? coord_t'(-1) : coord_t'(1));
        end
        if (move_y)
        begin
            ay_next = ay_reg + (sy_neg_reg ? coord_t'(-1) : coord_t'(1));
        end
        // both error corrections may apply in the same step
        err_next = err_reg - (move_x ? dy_reg : err_t'(0)) + (move_y ? dx_reg : err_t'(0));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            ax_reg     <= ctl.seg.ax;
            ay_reg     <= ctl.seg.ay;
            bx_reg     <= ctl.seg.bx;
            by_reg     <= ctl.seg.by;
            dx_reg     <= ldx;
            dy_reg     <= ldy;
            err_reg    <= ldx - ldy;
            sx_neg_reg <= !(ctl.seg.ax < ctl.seg.bx);
            sy_neg_reg <= !(ctl.seg.ay < ctl.seg.by);
        end
        else if (ctl.step)
        begin
            ax_reg  <= ax_next;
            ay_reg  <= ay_next;
            err_reg <= err_next;
        end
    end

    assign pos.x    = ax_reg;
    assign pos.y    = ay_reg;
    assign pos.last = (ax_reg == bx_reg) && (ay_reg == by_reg);

endmodule

`default_nettype wire

// File: sv/mono_page_framebuffer_draw_engine.sv
// drawing engine for a 1-bit page-organised framebuffer held in one synchronous ram
// request channel: req_valid / req_stall / req_data, one command per item
// result channel: res_valid / res_stall / res_data, exactly one result per command
// one command is worked on at a time; req_stall is high from acceptance until the
// result has been handed to the output register, which may still hold the previous
// result while the next command runs
// what each command does, from acceptance to result in the output register:
//   set / clear pixel: one read-modify-write, or none when the pixel is off the display
//   line: a read-modify-write per pixel on the display; pixels off it are stepped over
//   outline: the four sides in turn, each walked like a line
//   filled rectangle: a read-modify-write per byte touched (columns x pages)
//   read byte: a ram read on the display, zero returned off it;  unused code: no ram access
//   clear screen: all STORE_BYTES bytes are written to zero
// the next item can be taken in the cycle after the result is loaded
// every pixel drawn on the display is a read-modify-write through the single ram
// port pair: its byte is read, then written back with the pixel's bit changed
// after reset the ram is swept to zero, one byte a cycle, with req_stall high;
// no result is produced for that pass
// a stalled result stays in the output register; the engine finishes the
// command in hand and waits for the register to free before taking another
`default_nettype none

module mono_page_framebuffer_draw_engine
    import mpfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req_data,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_data
);

    state_e    state_reg, state_next;
    req_item_t cmd_reg, cmd_next;
    logic [1:0] seg_reg, seg_next;
    addr_t     clr_cnt_reg, clr_cnt_next;
    logic      pend_reg, pend_next;
    coord_t    fx_reg, fx_next;
    coord_t    fp_reg, fp_next;
    coord_t    fx0_reg, fx0_next;
    coord_t    fx_last_reg, fx_last_next;
    coord_t    fp_last_reg, fp_last_next;
    coord_t    fy0_reg, fy0_next;
    coord_t    fy1_reg, fy1_next;
    logic [7:0] rd_byte_reg, rd_byte_next;
    logic      res_valid_reg, res_valid_next;
    res_item_t res_data_reg;
    logic      res_load;

    logic       ram_we, ram_re;
    addr_t      ram_waddr, ram_raddr;
    logic [7:0] ram_wdata, ram_rdata;

    walk_ctl_t walk_ctl;
    walk_pos_t walk_pos;

    coord_t    xs, ys, xe, ye, rw, rh, xr, yb;
    coord_t    fx0, fx1, fy0, fy1;
    logic      fill_empty;
    line_seg_t seg_sel;
    logic      seg_more;
    logic      lit;
    logic      pix_on;
    addr_t     pix_a, fill_a;
    logic [7:0] pix_mask, fill_mask;
    coord_t    page_row;

    mpfb_ram #(
        .DEPTH (STORE_BYTES),
        .WIDTH (8)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mpfb_walk u_walk (
        .clk (clk),
        .ctl (walk_ctl),
        .pos (walk_pos)
    );

    // command operands at coordinate width
    always_comb
    begin
        xs = coord_t'(cmd_reg.x_start);
        ys = coord_t'(cmd_reg.y_start);
        xe = coord_t'(cmd_reg.x_end);
        ye = coord_t'(cmd_reg.y_end);
        rw = coord_t'(cmd_reg.rect_width);
        rh = coord_t'(cmd_reg.rect_height);
        xr = xs + rw - coord_t'(1);
        yb = ys + rh - coord_t'(1);

        fx0 = (xs < 0) ? coord_t'(0) : xs;
        fy0 = (ys < 0) ? coord_t'(0) : ys;
        fx1 = xs + rw;
        fy1 = ys + rh;
        if (fx1 > coord_t'(DISPLAY_WIDTH))
        begin
            fx1 = coord_t'(DISPLAY_WIDTH);
        end
        if (fy1 > coord_t'(DISPLAY_HEIGHT))
        begin
            fy1 = coord_t'(DISPLAY_HEIGHT);
        end
        fill_empty = (fx0 >= fx1) || (fy0 >= fy1);

        // outline: top, right side down, bottom leftward, left side up
        priority if (cmd_reg.req_type == REQ_LINE)
        begin
            seg_sel = '{ax: xs, ay: ys, bx: xe, by: ye};
        end
        else if (cmd_reg.req_type == REQ_RECT)
        begin
            unique case (seg_reg)
                2'd0: seg_sel = '{ax: xs, ay: ys, bx: xr, by: ys};
                2'd1: seg_sel = '{ax: xr, ay: ys, bx: xr, by: yb};
                2'd2: seg_sel = '{ax: xr, ay: yb, bx: xs, by: yb};
                2'd3: seg_sel = '{ax: xs, ay: yb, bx: xs, by: ys};
            endcase
        end
        else
        begin
            seg_sel = '{ax: xs, ay: ys, bx: xs, by: ys};
        end
        seg_more = (cmd_reg.req_type == REQ_RECT) && (seg_reg != 2'd3);
        lit      = cmd_reg.req_type != REQ_CLR_PIXEL;

        pix_on   = on_display(walk_pos.x, walk_pos.y);
        pix_a    = pix_addr(walk_pos.x, walk_pos.y);
        pix_mask = 8'd1 << walk_pos.y[ROW_W-1:0];

        fill_a   = page_addr(fx_reg, fp_reg);
        page_row = fp_reg <<< ROW_W;
        for (int b = 0; b < PAGE_ROWS; b++)
        begin
            fill_mask[b] = (page_row + coord_t'(b) >= fy0_reg)
                        && (page_row + coord_t'(b) < fy1_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        seg_next       = seg_reg;
        clr_cnt_next   = clr_cnt_reg;
        pend_next      = pend_reg;
        fx_next        = fx_reg;
        fp_next        = fp_reg;
        fx0_next       = fx0_reg;
        fx_last_next   = fx_last_reg;
        fp_last_next   = fp_last_reg;
        fy0_next       = fy0_reg;
        fy1_next       = fy1_reg;
        rd_byte_next   = rd_byte_reg;
        res_load       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        walk_ctl.load  = 1'b0;
        walk_ctl.step  = 1'b0;
        walk_ctl.seg   = seg_sel;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == addr_t'(STORE_BYTES - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = pend_reg ? ST_RESP : ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + addr_t'(1);
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req_data;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                rd_byte_next = '0;
                seg_next     = '0;
                pend_next    = 1'b1;
                unique case (cmd_reg.req_type)
                    REQ_CLEAR:
                    begin
                        clr_cnt_next = '0;
                        state_next   = ST_CLEAR;
                    end
                    REQ_SET_PIXEL, REQ_CLR_PIXEL, REQ_LINE, REQ_RECT:
                    begin
                        state_next = ST_SEG_LOAD;
                    end
                    REQ_FILL:
                    begin
                        fx_next      = fx0;
                        fp_next      = fy0 >>> ROW_W;
                        fx0_next     = fx0;
                        fx_last_next = fx1 - coord_t'(1);
                        fp_last_next = (fy1 - coord_t'(1)) >>> ROW_W;
                        fy0_next     = fy0;
                        fy1_next     = fy1;
                        state_next   = fill_empty ? ST_RESP : ST_FILL_RD;
                    end
                    REQ_READ:
                    begin
                        if (on_display(xs, ys))
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = pix_addr(xs, ys);
                            state_next = ST_READ_WAIT;
                        end
                        else
                        begin
                            state_next = ST_RESP;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_SEG_LOAD:
            begin
                walk_ctl.load = 1'b1;
                state_next    = ST_LINE_RD;
            end
            ST_LINE_RD:
            begin
                // off-display pixels touch nothing; the walk steps on without leaving this state
                if (pix_on)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = pix_a;
                    state_next = ST_LINE_WR;
                end
                else if (walk_pos.last)
                begin
                    seg_next   = seg_reg + 2'd1;
                    state_next = seg_more ? ST_SEG_LOAD : ST_RESP;
                end
                else
                begin
                    walk_ctl.step = 1'b1;
                end
            end
            ST_LINE_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = pix_a;
                ram_wdata = lit ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
                if (walk_pos.last)
                begin
                    seg_next   = seg_reg + 2'd1;
                    state_next = seg_more ? ST_SEG_LOAD : ST_RESP;
                end
                else
                begin
                    walk_ctl.step = 1'b1;
                    state_next    = ST_LINE_RD;
                end
            end
            ST_FILL_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = fill_a;
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = fill_a;
                ram_wdata  = ram_rdata | fill_mask;
                state_next = ST_FILL_RD;
                if (fx_reg == fx_last_reg)
                begin
                    fx_next = fx0_reg;
                    if (fp_reg == fp_last_reg)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        fp_next = fp_reg + coord_t'(1);
                    end
                end
                else
                begin
                    fx_next = fx_reg + coord_t'(1);
                end
            end
            ST_READ_WAIT:
            begin
                rd_byte_next = ram_rdata;
                state_next   = ST_RESP;
            end
            ST_RESP:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            seg_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pend_reg      <= pend_next;
            seg_reg       <= seg_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        fx_reg      <= fx_next;
        fp_reg      <= fp_next;
        fx0_reg     <= fx0_next;
        fx_last_reg <= fx_last_next;
        fp_last_reg <= fp_last_next;
        fy0_reg     <= fy0_next;
        fy1_reg     <= fy1_next;
        rd_byte_reg <= rd_byte_next;
        if (res_load)
        begin
            res_data_reg.done_res  <= 1'b1;
            res_data_reg.read_byte <= rd_byte_reg;
        end
    end

    assign req_stall = state_reg != ST_IDLE;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

`default_nettype wire

// File: sv/mpfb_check.sv
`default_nettype none
`include "assert_macros.svh"

module mpfb_check
    import mpfb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input logic      res_valid,
    input logic      res_stall,
    input res_item_t res_data
);

    `MPFB_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid)
    `MPFB_ASSERT_NXT(a_res_stable, clk, rst_n, res_valid && res_stall, $stable(res_data))
    `MPFB_ASSERT_IMP(a_done_set, clk, rst_n, res_valid, res_data.done_res)
    `MPFB_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall)

endmodule

bind mono_page_framebuffer_draw_engine mpfb_check u_check (.*);

`default_nettype wire

// File: tb/tb_mono_page_framebuffer_draw_engine.sv
`timescale 1ns / 1ps

import mpfb_pkg::*;

typedef logic signed [FIELD_W-1:0] field_t;

// command code the block leaves unused
localparam logic [2:0] REQ_SPARE = 3'd7;

class page_store_checker;
    logic [7:0] pix_bytes [STORE_BYTES];
    res_item_t  due_results [$];
    int         fail_count;

    function new();
        wipe();
        fail_count = 0;
    endfunction

    function void wipe();
        foreach (pix_bytes[i])
        begin
            pix_bytes[i] = 8'h00;
        end
    endfunction

    function bit visible(int x, int y);
        return x >= 0 && x < DISPLAY_WIDTH && y >= 0 && y < DISPLAY_HEIGHT;
    endfunction

    function void plot(int x, int y, bit lit);
        int a;
        logic [7:0] m;
        if (!visible(x, y))
            return;
        a = x + (y / PAGE_ROWS) * DISPLAY_WIDTH;
        m = 8'd1 << (y % PAGE_ROWS);
        if (lit)
            pix_bytes[a] = pix_bytes[a] | m;
        else
            pix_bytes[a] = pix_bytes[a] & ~m;
    endfunction

    function void trace_line(int ax, int ay, int bx, int by);
        int dx;
        int dy;
        int sx;
        int sy;
        int err;
        int e2;
        dx = (bx > ax) ? bx - ax : ax - bx;
        dy = (by > ay) ? by - ay : ay - by;
        sx = (ax < bx) ? 1 : -1;
        sy = (ay < by) ? 1 : -1;
        err = dx - dy;
        while (1)
        begin
            plot(ax, ay, 1'b1);
            if (ax == bx && ay == by)
                break;
            e2 = 2 * err;
            if (e2 > -dy)
            begin
                err -= dy;
                ax += sx;
            end
            if (e2 < dx)
            begin
                err += dx;
                ay += sy;
            end
        end
    endfunction

    function void fill_area(int x, int y, int w, int h);
        int x0;
        int y0;
        int x1;
        int y1;
        x0 = (x < 0) ? 0 : x;
        y0 = (y < 0) ? 0 : y;
        x1 = x + w;
        y1 = y + h;
        if (x1 > DISPLAY_WIDTH)
            x1 = DISPLAY_WIDTH;
        if (y1 > DISPLAY_HEIGHT)
            y1 = DISPLAY_HEIGHT;
        for (int j = y0; j < y1; j++)
        begin
            for (int i = x0; i < x1; i++)
            begin
                plot(i, j, 1'b1);
            end
        end
    endfunction

    function void note_command(req_item_t c);
        int xs;
        int ys;
        int xe;
        int ye;
        int w;
        int h;
        int xr;
        int yb;
        res_item_t r;
        xs = int'($signed(c.x_start));
        ys = int'($signed(c.y_start));
        xe = int'($signed(c.x_end));
        ye = int'($signed(c.y_end));
        w  = int'($signed(c.rect_width));
        h  = int'($signed(c.rect_height));
        r.done_res  = 1'b1;
        r.read_byte = 8'h00;
        case (c.req_type)
            REQ_CLEAR:     wipe();
            REQ_SET_PIXEL: plot(xs, ys, 1'b1);
            REQ_CLR_PIXEL: plot(xs, ys, 1'b0);
            REQ_LINE:      trace_line(xs, ys, xe, ye);
            REQ_RECT:
            begin
                // corners are taken at full width, no wrap
                xr = xs + w - 1;
                yb = ys + h - 1;
                trace_line(xs, ys, xr, ys);
                trace_line(xr, ys, xr, yb);
                trace_line(xr, yb, xs, yb);
                trace_line(xs, yb, xs, ys);
            end
            REQ_FILL:      fill_area(xs, ys, w, h);
            REQ_READ:
            begin
                if (visible(xs, ys))
                    r.read_byte = pix_bytes[xs + (ys / PAGE_ROWS) * DISPLAY_WIDTH];
            end
            default: ;
        endcase
        due_results.push_back(r);
    endfunction

    function void check_result(res_item_t got);
        res_item_t want;
        if (due_results.size() == 0)
        begin
            $error("result with no command outstanding: done_res %0d read_byte %0h",
                   got.done_res, got.read_byte);
            fail_count++;
            return;
        end
        want = due_results.pop_front();
        if (got.done_res !== want.done_res)
        begin
            $error("done_res: expected %0d, actual %0d", want.done_res, got.done_res);
            fail_count++;
        end
        if (got.read_byte !== want.read_byte)
        begin
            $error("read_byte: expected %0h, actual %0h", want.read_byte, got.read_byte);
            fail_count++;
        end
    endfunction

    function int pending();
        return due_results.size();
    endfunction
endclass

module tb_mono_page_framebuffer_draw_engine;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req_data;
    logic      res_valid;
    logic      res_stall;
    res_item_t res_data;

    bit calm;

    page_store_checker fb_check = new();

    mono_page_framebuffer_draw_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog, several times longer than the slowest run this stimulus can make
    initial
    begin
        #80_000_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
            fb_check.check_result(res_data);
        if (req_valid && !req_stall)
            fb_check.note_command(req_data);
    end

    function automatic int idle_len(bit allow_zero);
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 8)
            return $urandom_range(12, 60);
        if (allow_zero && r < 55)
            return 0;
        return $urandom_range(1, 4);
    endfunction

    // result side stalls
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            res_stall <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            if (!calm)
            begin
                res_stall <= 1'b1;
                repeat (idle_len(1'b0)) @(posedge clk);
            end
        end
    end

    function automatic field_t pick_near(int lo, int hi);
        return field_t'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    function automatic field_t pick_col(int far_pct);
        if ($urandom_range(0, 99) < far_pct)
            return field_t'($urandom);
        return pick_near(-12, DISPLAY_WIDTH + 11);
    endfunction

    function automatic field_t pick_row(int far_pct);
        if ($urandom_range(0, 99) < far_pct)
            return field_t'($urandom);
        return pick_near(-12, DISPLAY_HEIGHT + 11);
    endfunction

    function automatic field_t pick_span(int far_pct, int hi);
        if ($urandom_range(0, 99) < far_pct)
            return field_t'($urandom);
        return pick_near(-6, hi);
    endfunction

    function automatic req_item_t mk(logic [2:0] req, int xs, int ys, int xe, int ye,
                                     int w, int h);
        req_item_t c;
        c.req_type    = req;
        c.x_start     = field_t'(xs);
        c.y_start     = field_t'(ys);
        c.x_end       = field_t'(xe);
        c.y_end       = field_t'(ye);
        c.rect_width  = field_t'(w);
        c.rect_height = field_t'(h);
        return c;
    endfunction

    function automatic req_item_t random_command();
        req_item_t c;
        int r;
        // fields a command ignores get any value
        c.x_start     = field_t'($urandom);
        c.y_start     = field_t'($urandom);
        c.x_end       = field_t'($urandom);
        c.y_end       = field_t'($urandom);
        c.rect_width  = field_t'($urandom);
        c.rect_height = field_t'($urandom);
        r = $urandom_range(0, 999);
        if (r < 20)
        begin
            c.req_type = REQ_CLEAR;
        end
        else if (r < 300)
        begin
            c.req_type = (r < 200) ? REQ_SET_PIXEL : REQ_CLR_PIXEL;
            c.x_start  = pick_col(5);
            c.y_start  = pick_row(5);
        end
        else if (r < 520)
        begin
            c.req_type = REQ_LINE;
            c.x_start  = pick_col(3);
            c.y_start  = pick_row(3);
            c.x_end    = pick_col(3);
            c.y_end    = pick_row(3);
        end
        else if (r < 720)
        begin
            c.req_type    = (r < 620) ? REQ_RECT : REQ_FILL;
            c.x_start     = pick_col(2);
            c.y_start     = pick_row(2);
            c.rect_width  = pick_span(2, 90);
            c.rect_height = pick_span(2, 50);
        end
        else if (r < 980)
        begin
            c.req_type = REQ_READ;
            c.x_start  = pick_col(5);
            c.y_start  = pick_row(5);
        end
        else
        begin
            c.req_type = REQ_SPARE;
        end
        return c;
    endfunction

    task automatic send_cmd(req_item_t c);
        int gap;
        gap = idle_len(1'b1);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= c;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic run_directed();
        send_cmd(mk(REQ_READ,        0,     0,     0,    0,     0,     0));
        send_cmd(mk(REQ_SET_PIXEL,   0,     0,  2047, -2048, 2047, -2048));
        send_cmd(mk(REQ_READ,        0,     0,     0,    0,     0,     0));
        send_cmd(mk(REQ_SET_PIXEL, 127,    63,     0,    0,     0,     0));
        send_cmd(mk(REQ_READ,      127,    63, -2048, 2047, -2048,  2047));
        send_cmd(mk(REQ_SET_PIXEL,  -1,     5,     0,    0,     0,     0));
        send_cmd(mk(REQ_SET_PIXEL, 2047, -2048,    0,    0,     0,     0));
        send_cmd(mk(REQ_CLR_PIXEL,   0,     0,     0,    0,     0,     0));
        send_cmd(mk(REQ_READ,        0,     0,     0,    0,     0,     0));
        send_cmd(mk(REQ_READ,    -2048,  2047,     0,    0,     0,     0));
        send_cmd(mk(REQ_READ,      128,    64,     0,    0,     0,     0));
        // single point, shallow reversed, steep crossing the top edge, full diagonal
        send_cmd(mk(REQ_LINE,        3,     3,     3,    3,     0,     0));
        send_cmd(mk(REQ_LINE,      120,     2,    10,   40,     0,     0));
        send_cmd(mk(REQ_LINE,        5,    60,    20,  -10,     0,     0));
        send_cmd(mk(REQ_LINE,    -2048, -2048,  2047, 2047,     0,     0));
        send_cmd(mk(REQ_READ,       10,    10,     0,    0,     0,     0));
        // outlines with empty, negative and far-out sizes
        send_cmd(mk(REQ_RECT,       20,    20,     0,    0,     0,     0));
        send_cmd(mk(REQ_RECT,       60,    30,     0,    0,    -5,     7));
        send_cmd(mk(REQ_RECT,     2047,  2047,     0,    0,  2047,  2047));
        send_cmd(mk(REQ_RECT,    -2048, -2048,     0,    0, -2048, -2048));
        send_cmd(mk(REQ_RECT,      100,    50,     0,    0,    40,    30));
        send_cmd(mk(REQ_FILL,       10,    10,     0,    0,    -3,     5));
        send_cmd(mk(REQ_FILL,     -100,  -100,     0,    0,  2047,  2047));
        send_cmd(mk(REQ_READ,       64,    32,     0,    0,     0,     0));
        send_cmd(mk(REQ_SPARE,       0,     0,     0,    0,     0,     0));
        send_cmd(mk(REQ_CLEAR,       0,     0,     0,    0,     0,     0));
        send_cmd(mk(REQ_READ,       64,    32,     0,    0,     0,     0));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        calm      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (int n = 0; n < 1125; n++)
        begin
            // stretches with no idling on either side
            if (n % 100 == 0)
                calm <= ($urandom_range(0, 3) == 0);
            send_cmd(random_command());
        end
        req_valid <= 1'b0;
        calm      <= 1'b0;

        while (fb_check.pending() != 0) @(posedge clk);
        repeat (100) @(posedge clk);

        if (fb_check.fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: mono_page_framebuffer_draw_engine.f
+incdir+sv
sv/mpfb_pkg.sv
sv/mpfb_ram.sv
sv/mpfb_walk.sv
sv/mono_page_framebuffer_draw_engine.sv
sv/mpfb_check.sv
tb/tb_mono_page_framebuffer_draw_engine.sv
